// ===== sv/pvce_pkg.sv =====
package pvce_pkg;

    // field widths fixed by the command format
    localparam int MODE_W      = 3;
    localparam int COORD_W     = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int CHAR_W      = 8;
    localparam int ORIGIN_W    = 14;
    localparam int PEN_W       = 7;

    // full scale of a normalised coordinate
    localparam logic [COORD_W-1:0] FULL_SCALE = 15'd32767;

    // binary to bcd conversion: bits per value, bits per cycle
    localparam int CONV_BITS  = 24;
    localparam int STEP_BITS  = 3;
    localparam int CONV_STEPS = CONV_BITS / STEP_BITS;
    localparam int CNT_W      = $clog2(CONV_STEPS + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_BEGIN = 3'd0,
        MODE_FRAME = 3'd1,
        MODE_MOVE  = 3'd2,
        MODE_DRAW  = 3'd3,
        MODE_WIDTH = 3'd4,
        MODE_END   = 3'd5
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X  = 3'd0,
        CFG_ORIGIN_Y  = 3'd1,
        CFG_SPAN_X    = 3'd2,
        CFG_SPAN_Y    = 3'd3,
        CFG_PEN_BASE  = 3'd4,
        CFG_PEN_SLOPE = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [ORIGIN_W-1:0] span_x;
        logic [ORIGIN_W-1:0] span_y;
        logic [PEN_W-1:0]    pen_base;
        logic [PEN_W-1:0]    pen_slope;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        origin_x:  14'd30,
        origin_y:  14'd60,
        span_x:    14'd3180,
        span_y:    14'd2415,
        pen_base:  7'd3,
        pen_slope: 7'd4
    };

    // fixed command strings, first character in the top byte
    localparam int TEXT_LEN = 30;
    localparam logic [8*TEXT_LEN-1:0] INIT_TEXT = "\n^PY^-\n^ISYNTAX00010^IOL^F^IGV";
    localparam logic [8*TEXT_LEN-1:0] EXIT_TEXT = "^IGE^ISYNTAX00000^IOP^O\n^PN^-\n";

    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
    localparam logic [CHAR_W-1:0] CH_U     = 8'h55;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;

    function automatic logic [CHAR_W-1:0] text_char(
        input logic [8*TEXT_LEN-1:0] text,
        input logic [4:0]            pos
    );
        return text[8*(TEXT_LEN-1-int'(pos)) +: 8];
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib);
        return {4'h3, nib};
    endfunction

endpackage

// ===== sv/pvce_bcd.sv =====
module pvce_bcd #(
    parameter int DIGITS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [pvce_pkg::CONV_BITS-1:0] i_value,
    output logic [4*DIGITS-1:0]           o_bcd
);
    import pvce_pkg::*;

    logic [CONV_BITS-1:0] r_bin;
    logic [4*DIGITS-1:0]  r_bcd;
    logic [CONV_BITS-1:0] n_bin;
    logic [4*DIGITS-1:0]  n_bcd;

    // shift-add-3, several bits a cycle while i_step is high; digits above the kept ones fall off
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        for (int s = 0; s < STEP_BITS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[4*DIGITS-2:0], n_bin[CONV_BITS-1]};
            n_bin = n_bin << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_step) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_bcd = r_bcd;

endmodule

// ===== sv/pvce_front.sv =====
module pvce_front #(
    parameter int COORD_DIGITS = 4,
    parameter int PEN_DIGITS   = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pvce_pkg::t_cfg                   i_cfg,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pvce_pkg::MODE_W-1:0]      i_mode,
    input  logic [pvce_pkg::COORD_W-1:0]     i_coord_x,
    input  logic [pvce_pkg::COORD_W-1:0]     i_coord_y,
    input  logic                             i_full,
    output logic                             o_push,
    output pvce_pkg::t_mode                  o_mode,
    output logic [4*COORD_DIGITS-1:0]        o_x_bcd,
    output logic [4*COORD_DIGITS-1:0]        o_y_bcd,
    output logic [4*PEN_DIGITS-1:0]          o_pen_bcd
);
    import pvce_pkg::*;

    localparam int PROD_W = COORD_W + ORIGIN_W;
    localparam int PW_W   = COORD_W + PEN_W;

    // stage a: accepted command with its products
    logic               r_a_valid;
    t_mode              r_a_mode;
    logic [PROD_W-1:0]  r_a_px;
    logic [PROD_W-1:0]  r_a_py;
    logic [PW_W-1:0]    r_a_pw;
    logic               r_a_zero;

    // stage b: digit conversion
    logic               r_b_valid;
    t_mode              r_b_mode;
    logic [CNT_W-1:0]   r_b_cnt;

    logic               accept;
    logic               mode_ok;
    logic               b_done;
    logic               b_step;
    logic               b_free;
    logic               b_load;
    logic [COORD_W-1:0] pen_idx;
    logic [COORD_W-1:0] pen_idx_m1;
    logic [PW_W-1:0]    n_a_pw;
    logic [PEN_W-1:0]   pen_sat;
    logic [PW_W:0]      pen_val;
    logic [CNT_W-1:0]   n_b_cnt;
    logic [CONV_BITS-1:0] x_val;
    logic [CONV_BITS-1:0] y_val;
    logic [CONV_BITS-1:0] p_val;

    // floor(p / 32767) + origin: quotient by 2^15, then one correction
    function automatic logic [COORD_W-1:0] scale_coord(
        input logic [PROD_W-1:0]   prod,
        input logic [ORIGIN_W-1:0] origin
    );
        logic [ORIGIN_W-1:0] q0;
        logic [COORD_W:0]    rem;
        logic [COORD_W-1:0]  quo;
        q0  = prod[PROD_W-1:COORD_W];
        rem = {1'b0, prod[COORD_W-1:0]} + {2'b00, q0};
        quo = {1'b0, q0} + {{(COORD_W-1){1'b0}}, (rem >= {1'b0, FULL_SCALE})};
        return quo + {1'b0, origin};
    endfunction

    assign mode_ok    = (i_mode <= MODE_W'(MODE_END));
    assign accept     = i_in_valid && o_in_ready;
    assign b_done     = (r_b_cnt == CNT_W'(CONV_STEPS));
    assign b_step     = r_b_valid && !b_done;
    assign o_push     = r_b_valid && b_done && !i_full;
    assign b_free     = !r_b_valid || o_push;
    assign b_load     = r_a_valid && b_free;
    assign o_in_ready = !r_a_valid || b_free;

    // begin uses line width one
    assign pen_idx    = (i_mode == MODE_W'(MODE_BEGIN)) ? COORD_W'(1) : i_coord_x;
    assign pen_idx_m1 = pen_idx - COORD_W'(1);
    assign n_a_pw     = {{PEN_W{1'b0}}, pen_idx_m1} * {{COORD_W{1'b0}}, i_cfg.pen_slope};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= mode_ok;
            end else if (b_load) begin
                r_a_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (o_push) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_mode <= t_mode'(i_mode);
            r_a_px   <= {{ORIGIN_W{1'b0}}, i_coord_x} * {{COORD_W{1'b0}}, i_cfg.span_x};
            r_a_py   <= {{ORIGIN_W{1'b0}}, i_coord_y} * {{COORD_W{1'b0}}, i_cfg.span_y};
            r_a_pw   <= n_a_pw;
            r_a_zero <= (pen_idx == '0);
        end
        if (b_load) begin
            r_b_mode <= r_a_mode;
            r_b_cnt  <= n_b_cnt;
        end else if (b_step) begin
            r_b_cnt  <= r_b_cnt + CNT_W'(1);
        end
    end

    // width index zero can go negative: clamp at zero
    assign pen_sat = (i_cfg.pen_base >= i_cfg.pen_slope) ?
                     (i_cfg.pen_base - i_cfg.pen_slope) : '0;
    assign pen_val = r_a_zero ? {{(PW_W+1-PEN_W){1'b0}}, pen_sat} :
                     ({1'b0, r_a_pw} + {{(PW_W+1-PEN_W){1'b0}}, i_cfg.pen_base});

    assign x_val = CONV_BITS'(scale_coord(r_a_px, i_cfg.origin_x));
    assign y_val = CONV_BITS'(scale_coord(r_a_py, i_cfg.origin_y));
    assign p_val = CONV_BITS'(pen_val);

    // text-only commands skip the conversion
    always_comb begin
        if (r_a_mode inside {MODE_FRAME, MODE_END}) begin
            n_b_cnt = CNT_W'(CONV_STEPS);
        end else begin
            n_b_cnt = '0;
        end
    end

    pvce_bcd #(.DIGITS(COORD_DIGITS)) u_bcd_x (
        .i_clk   (i_clk),
        .i_load  (b_load),
        .i_step  (b_step),
        .i_value (x_val),
        .o_bcd   (o_x_bcd)
    );

    pvce_bcd #(.DIGITS(COORD_DIGITS)) u_bcd_y (
        .i_clk   (i_clk),
        .i_load  (b_load),
        .i_step  (b_step),
        .i_value (y_val),
        .o_bcd   (o_y_bcd)
    );

    pvce_bcd #(.DIGITS(PEN_DIGITS)) u_bcd_pen (
        .i_clk   (i_clk),
        .i_load  (b_load),
        .i_step  (b_step),
        .i_value (p_val),
        .o_bcd   (o_pen_bcd)
    );

    assign o_mode = r_b_mode;

endmodule

// ===== sv/pvce_queue.sv =====
module pvce_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;

    // pointers wrap at the last entry, so any depth works
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

// ===== sv/pvce_back.sv =====
module pvce_back #(
    parameter int COORD_DIGITS = 4,
    parameter int PEN_DIGITS   = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  pvce_pkg::t_mode               i_mode,
    input  logic [4*COORD_DIGITS-1:0]     i_x_bcd,
    input  logic [4*COORD_DIGITS-1:0]     i_y_bcd,
    input  logic [4*PEN_DIGITS-1:0]       i_pen_bcd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pvce_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_last_char
);
    import pvce_pkg::*;

    localparam int IDX_W = $clog2(TEXT_LEN + 3 + PEN_DIGITS);

    // character positions within each command
    localparam logic [IDX_W-1:0] BEGIN_PEN  = IDX_W'(TEXT_LEN);
    localparam logic [IDX_W-1:0] BEGIN_LAST = IDX_W'(TEXT_LEN + 2 + PEN_DIGITS);
    localparam logic [IDX_W-1:0] XY_COLON   = IDX_W'(2 + COORD_DIGITS);
    localparam logic [IDX_W-1:0] XY_LAST    = IDX_W'(2 + 2*COORD_DIGITS);
    localparam logic [IDX_W-1:0] WIDTH_LAST = IDX_W'(2 + PEN_DIGITS);
    localparam logic [IDX_W-1:0] TEXT_LAST  = IDX_W'(TEXT_LEN - 1);

    logic                       r_act;
    t_mode                      r_mode;
    logic [IDX_W-1:0]           r_idx;
    logic [4*COORD_DIGITS-1:0]  r_x;
    logic [4*COORD_DIGITS-1:0]  r_y;
    logic [4*PEN_DIGITS-1:0]    r_p;
    logic                       r_o_valid;
    logic [CHAR_W-1:0]          r_o_char;
    logic                       r_o_last;

    logic                       adv;
    logic [CHAR_W-1:0]          n_char;
    logic                       n_last;
    logic                       sh_x;
    logic                       sh_y;
    logic                       sh_p;

    assign adv     = r_act && (!r_o_valid || i_out_ready);
    assign o_q_pop = i_q_valid && (!r_act || (adv && n_last));

    always_comb begin
        n_char = CH_CARET;
        n_last = 1'b0;
        sh_x   = 1'b0;
        sh_y   = 1'b0;
        sh_p   = 1'b0;
        unique case (r_mode)
            MODE_BEGIN: begin
                if (r_idx < BEGIN_PEN) begin
                    n_char = text_char(INIT_TEXT, r_idx[4:0]);
                end else if (r_idx == BEGIN_PEN) begin
                    n_char = CH_CARET;
                end else if (r_idx == BEGIN_PEN + IDX_W'(1)) begin
                    n_char = CH_P;
                end else if (r_idx == BEGIN_PEN + IDX_W'(2)) begin
                    n_char = CH_W;
                end else begin
                    n_char = digit_char(r_p[4*PEN_DIGITS-1 -: 4]);
                    sh_p   = 1'b1;
                end
                n_last = (r_idx == BEGIN_LAST);
            end
            MODE_FRAME: begin
                n_char = (r_idx == '0) ? CH_CARET : CH_COMMA;
                n_last = (r_idx == IDX_W'(1));
            end
            MODE_MOVE, MODE_DRAW: begin
                if (r_idx == '0) begin
                    n_char = CH_CARET;
                end else if (r_idx == IDX_W'(1)) begin
                    n_char = (r_mode == MODE_MOVE) ? CH_U : CH_D;
                end else if (r_idx < XY_COLON) begin
                    n_char = digit_char(r_x[4*COORD_DIGITS-1 -: 4]);
                    sh_x   = 1'b1;
                end else if (r_idx == XY_COLON) begin
                    n_char = CH_COLON;
                end else begin
                    n_char = digit_char(r_y[4*COORD_DIGITS-1 -: 4]);
                    sh_y   = 1'b1;
                end
                n_last = (r_idx == XY_LAST);
            end
            MODE_WIDTH: begin
                if (r_idx == '0) begin
                    n_char = CH_CARET;
                end else if (r_idx == IDX_W'(1)) begin
                    n_char = CH_P;
                end else if (r_idx == IDX_W'(2)) begin
                    n_char = CH_W;
                end else begin
                    n_char = digit_char(r_p[4*PEN_DIGITS-1 -: 4]);
                    sh_p   = 1'b1;
                end
                n_last = (r_idx == WIDTH_LAST);
            end
            MODE_END: begin
                n_char = text_char(EXIT_TEXT, r_idx[4:0]);
                n_last = (r_idx == TEXT_LAST);
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
            end else if (adv && n_last) begin
                r_act <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mode <= i_mode;
            r_idx  <= '0;
            r_x    <= i_x_bcd;
            r_y    <= i_y_bcd;
            r_p    <= i_pen_bcd;
        end else if (adv) begin
            r_idx <= r_idx + IDX_W'(1);
            if (sh_x) begin
                r_x <= r_x << 4;
            end
            if (sh_y) begin
                r_y <= r_y << 4;
            end
            if (sh_p) begin
                r_p <= r_p << 4;
            end
        end
        if (adv) begin
            r_o_char <= n_char;
            r_o_last <= n_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_last_char = r_o_last;

endmodule

// ===== sv/plot_vector_command_encoder_core.sv =====
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------
// command   | in        | i_in_valid / o_in_ready   | i_mode, i_coord_x, i_coord_y
// character | out       | o_out_valid / i_out_ready | o_out_char, o_last_char
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one character per cycle on the output while i_out_ready is high and commands are queued:
// move and draw emit 11 characters, begin 33+PEN_DIGITS, set width 3+PEN_DIGITS, frame 2,
// end 30; modes 6 and 7 are taken with no output; the digit converter holds a numbered
// command until it is pushed; the character serialiser sets the sustained rate for move and
// draw; a numbered command goes through stage a, stage b, the queue and the output register
// synchronous active-low reset of the valid flags, pointers and configuration (CFG_RESET)
// output stalls back up through the command queue into the converter and then o_in_ready
module plot_vector_command_encoder_core #(
    parameter int COORD_DIGITS = 4,
    parameter int PEN_DIGITS   = 2,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pvce_pkg::MODE_W-1:0]         i_mode,
    input  logic [pvce_pkg::COORD_W-1:0]        i_coord_x,
    input  logic [pvce_pkg::COORD_W-1:0]        i_coord_y,
    // character channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pvce_pkg::CHAR_W-1:0]         o_out_char,
    output logic                                o_last_char,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pvce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pvce_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pvce_pkg::*;

    // queue entry: mode, pen digits, y digits, x digits
    localparam int XW     = 4 * COORD_DIGITS;
    localparam int PW     = 4 * PEN_DIGITS;
    localparam int ENTRY_W = MODE_W + PW + 2 * XW;

    t_cfg               r_cfg;

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_wr;
    logic [ENTRY_W-1:0] q_rd;

    t_mode              f_mode;
    logic [XW-1:0]      f_x;
    logic [XW-1:0]      f_y;
    logic [PW-1:0]      f_pen;

    // configuration registers, always ready; unknown indices are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ORIGIN_X:  r_cfg.origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_cfg.origin_y  <= i_cfg_data;
                CFG_SPAN_X:    r_cfg.span_x    <= i_cfg_data;
                CFG_SPAN_Y:    r_cfg.span_y    <= i_cfg_data;
                CFG_PEN_BASE:  r_cfg.pen_base  <= i_cfg_data[PEN_W-1:0];
                CFG_PEN_SLOPE: r_cfg.pen_slope <= i_cfg_data[PEN_W-1:0];
                default: ;
            endcase
        end
    end

    // front end: takes the command, scales and converts to decimal digits
    pvce_front #(
        .COORD_DIGITS (COORD_DIGITS),
        .PEN_DIGITS   (PEN_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_mode     (f_mode),
        .o_x_bcd    (f_x),
        .o_y_bcd    (f_y),
        .o_pen_bcd  (f_pen)
    );

    assign q_wr = {f_mode, f_pen, f_y, f_x};

    // decouples the converter from the character serialiser
    pvce_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rd)
    );

    // back end: one character per cycle into the output register unless the output stalls
    pvce_back #(
        .COORD_DIGITS (COORD_DIGITS),
        .PEN_DIGITS   (PEN_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_mode      (t_mode'(q_rd[ENTRY_W-1 -: MODE_W])),
        .i_x_bcd     (q_rd[XW-1:0]),
        .i_y_bcd     (q_rd[2*XW-1:XW]),
        .i_pen_bcd   (q_rd[2*XW+PW-1:2*XW]),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== sv/pvce_checker.sv =====
module pvce_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [pvce_pkg::MODE_W-1:0]      i_mode,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [pvce_pkg::CHAR_W-1:0]      o_out_char,
    input logic                             o_last_char
);
    import pvce_pkg::*;

    // commands taken that still owe their final character
    logic [7:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend
                    + 8'(i_in_valid && o_in_ready && (i_mode <= MODE_W'(MODE_END)))
                    - 8'(o_out_valid && i_out_ready && o_last_char);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("stalled character transaction changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 8'd0)
        else $error("character with no command outstanding");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 8'd0 |-> o_in_ready)
        else $error("not ready while idle");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind plot_vector_command_encoder_core pvce_checker u_pvce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char)
);
